// ----- hw/rtl/cdrs_pkg.sv -----
// Shared types, constants and crop tables for the canopy disease risk scorer.
// No dependencies; imported by canopy_disease_risk_scorer_core.
`default_nettype none

package cdrs_pkg;

  // Request payloads
  typedef struct packed {
    logic signed [15:0] leaf_temp;
    logic signed [15:0] dew_point;
    logic [14:0]        wetness_persistence;
    logic [14:0]        spore_fluorescence;
    logic [14:0]        air_stagnation;
    logic [13:0]        thermal_variance;
    logic [13:0]        carbon_dioxide_ppm;
  } cdrs_in_t;

  typedef struct packed {
    logic [14:0] blight_score;
    logic [1:0]  blight_level;
  } cdrs_out_t;

  // Crop codes; codes 6 and 7 fall back to the custom table
  localparam logic [2:0] CROP_GRAPE      = 3'd0;
  localparam logic [2:0] CROP_TOMATO     = 3'd1;
  localparam logic [2:0] CROP_STRAWBERRY = 3'd2;
  localparam logic [2:0] CROP_CUCUMBER   = 3'd3;
  localparam logic [2:0] CROP_HOPS       = 3'd4;
  localparam logic [2:0] CROP_CUSTOM     = 3'd5;

  // Risk level codes
  localparam logic [1:0] LEVEL_LOW      = 2'd0;
  localparam logic [1:0] LEVEL_MODERATE = 2'd1;
  localparam logic [1:0] LEVEL_ELEVATED = 2'd2;
  localparam logic [1:0] LEVEL_CRITICAL = 2'd3;

  // Scoring constants (1/256 points unless noted)
  localparam logic [14:0] FULL_SCORE    = 15'd25600;
  localparam logic [14:0] SCORE_CEILING = 15'd27200;
  localparam logic [14:0] CO2_LOW_SCORE = 15'd2560;
  localparam logic [14:0] CO2_HI_SCORE  = 15'd19200;
  localparam logic [13:0] CO2_LOW_PPM   = 14'd500;
  localparam logic [13:0] CO2_HI_PPM    = 14'd900;
  localparam logic [16:0] DEW_KNEE      = 17'd768;
  localparam logic [21:0] DEW_WET_BASE  = 22'd14080;
  localparam logic [21:0] DEW_WET_SLOPE = 22'd18;
  localparam logic [15:0] DEW_DRY_SLOPE = 16'd55;
  localparam logic [16:0] CO2_SLOPE     = 17'd208;
  localparam logic [17:0] THERM_SLOPE   = 18'd15;

  // Reciprocals for the constant divides: /3 as *43691>>17, /5 as *104858>>19
  localparam logic [31:0] RECIP_3 = 32'd43691;
  localparam logic [35:0] RECIP_5 = 36'd104858;

  // Component order: dew, wetness, spore, airflow, thermal, co2
  localparam int NUM_COMP = 6;

  typedef logic [NUM_COMP-1:0][14:0] weight_set_t;

  typedef struct packed {
    logic [14:0] critical;
    logic [14:0] elevated;
    logic [14:0] moderate;
  } limit_set_t;

  // Q0.16 weights per crop; element 0 is the dew weight
  function automatic weight_set_t crop_weights(input logic [2:0] crop);
    weight_set_t w;
    w[0] = 15'd19661; w[1] = 15'd14418; w[2] = 15'd11796;
    w[3] = 15'd9175;  w[4] = 15'd6554;  w[5] = 15'd3932;
    unique case (crop)
      CROP_GRAPE: begin
        w[1] = 15'd16384; w[2] = 15'd13107;
      end
      CROP_TOMATO: begin
        w[3] = 15'd11796; w[5] = 15'd5243;
      end
      CROP_STRAWBERRY: w[4] = 15'd9175;
      CROP_CUCUMBER:   w[0] = 15'd22282;
      CROP_HOPS:       w[2] = 15'd14418;
      default: ;
    endcase
    return w;
  endfunction

  function automatic limit_set_t crop_limits(input logic [2:0] crop);
    limit_set_t t;
    t.critical = 15'd19968;
    t.elevated = 15'd14336;
    t.moderate = 15'd8704;
    unique case (crop)
      CROP_STRAWBERRY: t.critical = 15'd18944;
      CROP_HOPS:       t.moderate = 15'd7680;
      default: ;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/canopy_disease_risk_scorer_core.sv -----
// Canopy disease risk scorer: component scoring, crop weighting, classification.
// Depends on cdrs_pkg (payload structs, crop tables, constants).
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall  | cdrs_in_t sensor record
//   out_    | result    | out_valid/out_stall| cdrs_out_t score and level
//   cfg_    | write     | cfg_valid/cfg_ready| 3-bit crop profile
//
// Six register stages: prepare, divide, weight, pair sums, total/saturate,
// classify into the output register. One request per cycle unless out_stall holds a full pipeline.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles
// collapse and in_stall rises only with all six stages full and out_stall high.
// Synchronous active-low reset empties the pipeline and sets the crop to grape.
// Configuration writes are always taken (cfg_ready is tied high).
`default_nettype none

module canopy_disease_risk_scorer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire cdrs_pkg::cdrs_in_t in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      cdrs_pkg::cdrs_out_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [2:0]         cfg_data
);
  import cdrs_pkg::*;

  // Crop register
  logic [2:0] crop_r;
  weight_set_t wts;
  limit_set_t  lims;

  assign cfg_ready = 1'b1;
  assign wts  = crop_weights(crop_r);
  assign lims = crop_limits(crop_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_r <= CROP_GRAPE;
    end else if (cfg_valid && cfg_ready) begin
      crop_r <= cfg_data;
    end
  end

  // Stage valids and advance chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5, adv_o;

  assign adv_o    = !out_valid_r || !out_stall;
  assign adv5     = !v5_r || adv_o;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (adv1)  v1_r <= in_valid;
      if (adv2)  v2_r <= v1_r;
      if (adv3)  v3_r <= v2_r;
      if (adv4)  v4_r <= v3_r;
      if (adv5)  v5_r <= v4_r;
      if (adv_o) out_valid_r <= v5_r;
    end
  end

  // Stage 1: dew margin, CO2 band, thermal scaling
  logic signed [16:0] margin;
  logic [16:0] neg_margin;
  logic [21:0] wet_val;
  logic [9:0]  dry_diff;
  logic [15:0] dew_num_nxt, dew_num_r;
  logic        dew_div_nxt, dew_div_r;
  logic [16:0] co2_num_nxt, co2_num_r;
  logic        co2_div_nxt, co2_div_r;
  logic [16:0] therm_raw;
  logic [14:0] therm_nxt, therm_r;
  logic [14:0] wet1_r, spore1_r, stag1_r;

  always_comb begin
    margin     = 17'(in_data.leaf_temp) - 17'(in_data.dew_point);
    neg_margin = 17'(-margin);
    wet_val    = DEW_WET_BASE + 22'(neg_margin) * DEW_WET_SLOPE;
    dry_diff   = 10'(DEW_KNEE - margin);
    dew_num_nxt = '0;
    dew_div_nxt = 1'b0;
    if (margin >= $signed(DEW_KNEE)) begin
      dew_num_nxt = '0;
    end else if (!margin[16]) begin
      dew_num_nxt = 16'(dry_diff) * DEW_DRY_SLOPE;
      dew_div_nxt = 1'b1;
    end else if (wet_val > 22'(FULL_SCORE)) begin
      dew_num_nxt = 16'(FULL_SCORE);
    end else begin
      dew_num_nxt = wet_val[15:0];
    end

    co2_div_nxt = 1'b0;
    if (in_data.carbon_dioxide_ppm < CO2_LOW_PPM) begin
      co2_num_nxt = 17'(CO2_LOW_SCORE);
    end else if (in_data.carbon_dioxide_ppm > CO2_HI_PPM) begin
      co2_num_nxt = 17'(CO2_HI_SCORE);
    end else begin
      co2_num_nxt = 17'(9'(in_data.carbon_dioxide_ppm - CO2_LOW_PPM)) * CO2_SLOPE;
      co2_div_nxt = 1'b1;
    end

    therm_raw = 17'((18'(in_data.thermal_variance) * THERM_SLOPE) >> 1);
    therm_nxt = (therm_raw > 17'(FULL_SCORE)) ? FULL_SCORE : therm_raw[14:0];
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      dew_num_r <= dew_num_nxt;
      dew_div_r <= dew_div_nxt;
      co2_num_r <= co2_num_nxt;
      co2_div_r <= co2_div_nxt;
      therm_r   <= therm_nxt;
      wet1_r    <= in_data.wetness_persistence;
      spore1_r  <= in_data.spore_fluorescence;
      stag1_r   <= in_data.air_stagnation;
    end
  end

  // Stage 2: constant divides by reciprocal multiply
  logic [31:0] dew_prod;
  logic [35:0] co2_prod;
  logic [NUM_COMP-1:0][14:0] comp_nxt, comp_r;

  always_comb begin
    dew_prod = 32'(dew_num_r) * RECIP_3;
    co2_prod = 36'(co2_num_r) * RECIP_5;
    comp_nxt[0] = dew_div_r ? dew_prod[31:17] : dew_num_r[14:0];
    comp_nxt[1] = wet1_r;
    comp_nxt[2] = spore1_r;
    comp_nxt[3] = stag1_r;
    comp_nxt[4] = therm_r;
    comp_nxt[5] = co2_div_r ? (CO2_LOW_SCORE + co2_prod[33:19]) : co2_num_r[14:0];
  end

  always_ff @(posedge clk) begin
    if (adv2) comp_r <= comp_nxt;
  end

  // Stage 3: weight each component
  logic [NUM_COMP-1:0][29:0] prod_nxt, prod_r;

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      prod_nxt[k] = 30'(comp_r[k]) * 30'(wts[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) prod_r <= prod_nxt;
  end

  // Stage 4: pair sums
  logic [2:0][30:0] pair_nxt, pair_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pair_nxt[k] = 31'(prod_r[2*k]) + 31'(prod_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) pair_r <= pair_nxt;
  end

  // Stage 5: total, drop fraction, saturate
  logic [32:0] total;
  logic [16:0] whole;
  logic [14:0] score_nxt, score_r;

  always_comb begin
    total     = 33'(pair_r[0]) + 33'(pair_r[1]) + 33'(pair_r[2]);
    whole     = total[32:16];
    score_nxt = (whole > 17'(SCORE_CEILING)) ? SCORE_CEILING : whole[14:0];
  end

  always_ff @(posedge clk) begin
    if (adv5) score_r <= score_nxt;
  end

  // Stage 6: classify against crop thresholds
  cdrs_out_t out_nxt, out_r;

  always_comb begin
    out_nxt.blight_score = score_r;
    priority if (score_r >= lims.critical) begin
      out_nxt.blight_level = LEVEL_CRITICAL;
    end else if (score_r >= lims.elevated) begin
      out_nxt.blight_level = LEVEL_ELEVATED;
    end else if (score_r >= lims.moderate) begin
      out_nxt.blight_level = LEVEL_MODERATE;
    end else begin
      out_nxt.blight_level = LEVEL_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) out_r <= out_nxt;
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  // Stall toward the source only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r))
    else $error("in_stall with an empty pipeline stage");

  // Delivered score never exceeds the ceiling
  a_score_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.blight_score <= SCORE_CEILING))
    else $error("blight_score above ceiling");

  // Level agrees with the lowest thresholds of any crop
  a_level_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.blight_score < 15'd7680) |-> (out_r.blight_level == LEVEL_LOW))
    else $error("blight_level not low below every moderate threshold");

  // Computed components stay within full scale
  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (comp_r[0] <= FULL_SCORE && comp_r[4] <= FULL_SCORE &&
              comp_r[5] <= CO2_HI_SCORE))
    else $error("component score out of range");

  // A request moving out of stage one lands in stage two
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv2) |=> v2_r)
    else $error("request lost between stage one and two");
`endif

endmodule

`default_nettype wire
